// ----- rtl/cftp_pkg.sv -----
// Shared types and constants for the constant fraction timing pick block.
// Holds the request/result payload structs and the pipeline structs that
// pass between the front end, the delay-line memory and the pick stage.
package cftp_pkg;

    localparam int MAX_TRACE_LEN = 1024;
    localparam int MAX_DELAY     = 64;
    localparam int HALF_WIDTH    = 2;
    localparam int WIN_TAPS      = 2 * HALF_WIDTH + 1;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + $clog2(WIN_TAPS);
    localparam int CNT_W    = $clog2(MAX_TRACE_LEN + 1);
    localparam int DLY_AW   = $clog2(MAX_DELAY);
    localparam int IDX_W    = 11;
    localparam int FRAC_W   = 16;
    localparam int DELAY_W  = 6;
    localparam int THR_W    = 20;
    localparam int CFG_DW   = 20;
    localparam int CFG_IW   = 2;
    localparam int PROD_W   = SUM_W + FRAC_W + 1;

    localparam logic [FRAC_W-1:0]         FRACTION_RST  = FRAC_W'(19661);
    localparam logic [DELAY_W-1:0]        DELAY_RST     = DELAY_W'(20);
    localparam logic signed [THR_W-1:0]   THRESHOLD_RST = THR_W'(2048);

    typedef enum logic [CFG_IW-1:0] {
        REG_FRACTION  = 2'd0,
        REG_DELAY     = 2'd1,
        REG_THRESHOLD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } sample_req_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] crossing_index;
        logic                    found;
        logic                    was_armed;
    } pick_rsp_t;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic                    j_ok;
        logic                    use_self;
        logic signed [IDX_W-1:0] crossing;
        logic signed [SUM_W-1:0] win_sum;
    } cftp_s1_t;

    typedef struct packed {
        logic                    we;
        logic                    re;
        logic [DLY_AW-1:0]       waddr;
        logic [DLY_AW-1:0]       raddr;
        logic signed [SUM_W-1:0] wdata;
    } cftp_mem_req_t;

endpackage

// ----- rtl/cftp_front.sv -----
// Front end: sample window, sample counter and delay-line addressing.
// Produces the first pipeline stage and the delay-line memory request.
// Depends on cftp_pkg.
module cftp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          adv,
    input  cftp_pkg::sample_req_t         req,
    input  logic [cftp_pkg::DELAY_W-1:0]  delay,
    output cftp_pkg::cftp_s1_t            s1,
    output cftp_pkg::cftp_mem_req_t       mem_req
);
    import cftp_pkg::*;

    localparam int CW1 = CNT_W + 1;

    logic signed [SAMPLE_W-1:0] taps_reg [0:WIN_TAPS-2];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [DLY_AW-1:0]          pos_reg, pos_next;
    cftp_s1_t                   s1_reg, s1_next;

    logic signed [SUM_W-1:0]    win_sum;
    logic                       proc;
    logic                       full_win;
    logic [CW1-1:0]             count_x;
    logic [CW1-1:0]             cross_x;

    always_comb
    begin
        win_sum = SUM_W'(req.sample);
        for (int i = 0; i < WIN_TAPS - 1; i++)
        begin
            win_sum = win_sum + SUM_W'(taps_reg[i]);
        end
        proc     = count_reg < CNT_W'(MAX_TRACE_LEN);
        full_win = count_reg >= CNT_W'(2 * HALF_WIDTH);
        count_x  = CW1'(count_reg);
        cross_x  = count_x - CW1'(delay) - CW1'(HALF_WIDTH + 1);

        count_next = count_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (req.last_sample)
            begin
                count_next = '0;
                pos_next   = '0;
            end
            else if (proc)
            begin
                count_next = count_reg + CNT_W'(1);
                if (full_win)
                begin
                    pos_next = pos_reg + DLY_AW'(1);
                end
            end
        end

        s1_next.valid    = accept;
        s1_next.last     = req.last_sample;
        s1_next.j_ok     = proc && full_win
                           && (count_x >= CW1'(delay) + CW1'(2 * HALF_WIDTH));
        s1_next.use_self = (delay == '0);
        s1_next.crossing = cross_x[IDX_W-1:0];
        s1_next.win_sum  = win_sum;

        mem_req.we    = accept && proc && full_win;
        mem_req.re    = adv;
        mem_req.waddr = pos_reg;
        mem_req.raddr = pos_reg - DLY_AW'(delay);
        mem_req.wdata = win_sum;
    end

    // window taps carry no reset: a sum is used only once all taps are from this trace
    always_ff @(posedge clk)
    begin
        if (accept && proc)
        begin
            for (int i = 0; i < WIN_TAPS - 2; i++)
            begin
                taps_reg[i] <= taps_reg[i + 1];
            end
            taps_reg[WIN_TAPS-2] <= req.sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            s1_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            if (adv)
            begin
                s1_reg <= s1_next;
            end
        end
    end

    assign s1 = s1_reg;

endmodule

// ----- rtl/cftp_dline.sv -----
// Delay line of smoothed sums: one synchronous memory, one write port and
// one registered read port. Depends on cftp_pkg.
module cftp_dline (
    input  logic                              clk,
    input  cftp_pkg::cftp_mem_req_t           mem_req,
    output logic signed [cftp_pkg::SUM_W-1:0] rd_data
);
    import cftp_pkg::*;

    logic signed [SUM_W-1:0] mem [0:MAX_DELAY-1];
    logic signed [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/cftp_pick.sv -----
// Fraction multiply, CFD value, arm/crossing decision and result register.
// Also produces the pipeline advance used by the whole block.
// Depends on cftp_pkg.
module cftp_pick (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cftp_pkg::cftp_s1_t                s1,
    input  logic signed [cftp_pkg::SUM_W-1:0] rd_data,
    input  logic [cftp_pkg::FRAC_W-1:0]       fraction,
    input  logic signed [cftp_pkg::THR_W-1:0] threshold,
    input  logic                              out_ready,
    output logic                              out_valid,
    output cftp_pkg::pick_rsp_t               out_data,
    output logic                              adv
);
    import cftp_pkg::*;

    localparam int FQ_W  = PROD_W - FRAC_W;
    localparam int CFD_W = FQ_W + 1;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic                     j_ok;
        logic signed [IDX_W-1:0]  crossing;
        logic signed [SUM_W-1:0]  earlier;
        logic signed [PROD_W-1:0] prod;
    } cftp_s2_t;

    cftp_s2_t                s2_reg;
    logic                    armed_reg, armed_next;
    logic                    done_reg, done_next;
    logic signed [IDX_W-1:0] cross_reg, cross_next;
    logic                    out_valid_reg;
    pick_rsp_t               out_data_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [FQ_W-1:0]   frac_part;
    logic signed [CFD_W-1:0]  cfd;
    logic                     test;
    logic                     arm_hit;
    logic                     cross_hit;
    logic                     emit;

    assign adv  = !out_valid_reg || out_ready;
    assign prod = PROD_W'(s1.win_sum) * PROD_W'($signed({1'b0, fraction}));

    always_comb
    begin
        // arithmetic shift right by 16 gives the floor of the fraction product
        frac_part  = s2_reg.prod[PROD_W-1:FRAC_W];
        cfd        = CFD_W'(s2_reg.earlier) - CFD_W'(frac_part);
        test       = s2_reg.valid && s2_reg.j_ok && !done_reg;
        arm_hit    = test && (cfd < CFD_W'(threshold));
        armed_next = armed_reg || arm_hit;
        cross_hit  = test && armed_next && (cfd < 0);
        done_next  = done_reg || cross_hit;
        cross_next = cross_hit ? s2_reg.crossing : cross_reg;
        emit       = adv && s2_reg.valid && s2_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            armed_reg     <= 1'b0;
            done_reg      <= 1'b0;
            cross_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s2_reg.valid    <= s1.valid;
                s2_reg.last     <= s1.last;
                s2_reg.j_ok     <= s1.j_ok;
                s2_reg.crossing <= s1.crossing;
                s2_reg.earlier  <= s1.use_self ? s1.win_sum : rd_data;
                s2_reg.prod     <= prod;
                if (s2_reg.valid)
                begin
                    // drop trace state once its result is taken into the output
                    if (s2_reg.last)
                    begin
                        armed_reg <= 1'b0;
                        done_reg  <= 1'b0;
                        cross_reg <= '1;
                    end
                    else
                    begin
                        armed_reg <= armed_next;
                        done_reg  <= done_next;
                        cross_reg <= cross_next;
                    end
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.crossing_index <= cross_next;
            out_data_reg.found          <= done_next;
            out_data_reg.was_armed      <= armed_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_found_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.found || out_data_reg.was_armed))
        else $error("result found without armed");

    a_none_is_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found) |-> (out_data_reg.crossing_index == '1))
        else $error("crossing index set without a crossing");

    a_done_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> armed_reg)
        else $error("crossing recorded while not armed");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (!armed_reg && !done_reg && out_valid_reg))
        else $error("trace state not cleared after last sample");

endmodule

// ----- rtl/constant_fraction_timing_pick.sv -----
// Constant fraction timing pick: one sample request per cycle in unless a
// result stalls, one result per trace out. Configuration register file and
// top-level wiring. Depends on cftp_pkg, cftp_front, cftp_dline and cftp_pick.
//
// Usage:
//   in_valid/in_ready/in_data carry one trace sample per request; the
//   request with last_sample set closes the trace and yields one result on
//   out_valid/out_ready/out_data. Other samples yield nothing.
//   Throughput is one sample per cycle while results are taken; the only
//   loop is the read-modify of the arm/crossing flags.
//   Pipeline: the window sum and the memory read are registered when a
//   sample is accepted, the fraction multiply is registered with the delayed
//   sum, and the decision for a last sample goes into the output register.
//   A stalled result holds the whole pipeline, so in_ready drops only while
//   a result sits unaccepted and out_ready is low.
//   Reset clears the counters, flags and output valid; configuration returns to
//   fraction 19661, delay 20, threshold 2048. The delay memory needs no
//   clearing pass: an entry is used only after it was written in the trace.
//   cfg_ready is always high; write registers only while the block is idle.
module constant_fraction_timing_pick (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cftp_pkg::sample_req_t        in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cftp_pkg::pick_rsp_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cftp_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [cftp_pkg::CFG_DW-1:0]  cfg_data
);
    import cftp_pkg::*;

    logic [FRAC_W-1:0]       fraction_reg;
    logic [DELAY_W-1:0]      delay_reg;
    logic signed [THR_W-1:0] threshold_reg;

    logic          accept;
    logic          adv;
    cftp_s1_t      s1;
    cftp_mem_req_t mem_req;
    logic signed [SUM_W-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = adv;
    assign accept    = in_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_reg  <= FRACTION_RST;
            delay_reg     <= DELAY_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRACTION:  fraction_reg  <= cfg_data[FRAC_W-1:0];
                REG_DELAY:     delay_reg     <= cfg_data[DELAY_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    cftp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .adv     (adv),
        .req     (in_data),
        .delay   (delay_reg),
        .s1      (s1),
        .mem_req (mem_req)
    );

    cftp_dline u_dline (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    cftp_pick u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .rd_data   (rd_data),
        .fraction  (fraction_reg),
        .threshold (threshold_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .adv       (adv)
    );

endmodule
